// File: rtl/core/slr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants for the stereo linear resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATIO_W     = 18;
  localparam int CNT_W       = 2;
  localparam int MAX_RESULTS = 4;

  // 49716 << 16 / 44100
  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd73881;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic last;
    logic write;
  } ctl_cmd_t;

  typedef struct packed {
    logic acc_below_one;
    logic next_below_one;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/stereo_linear_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// Source-driven stereo sample-rate converter with linear interpolation.
// ----------------------------------------------------------------------------
// Each input word is one source stereo pair and produces zero to four output
// words, the last of them flagged by tlast. rate_ratio (source samples per
// output, FRACTION_BITS fractional bits) is written through cfg_wr_en /
// cfg_wr_data and also reloads the phase accumulator; write it only while
// the block is idle. An input word is taken in the idle state; the
// controller then steps through a check and a write state per output, with
// the multiply registered between them, and a word that yields none needs
// only one check; downstream stalls hold the write state. The output
// register lets the next input word be taken while the last output still waits.
module stereo_linear_resampler #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [slr_pkg::RATIO_W-1:0]       cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*slr_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // src_left, src_right
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*slr_pkg::SAMPLE_W-1:0]    m_axis_tdata,  // out_left, out_right
  output logic                              m_axis_tlast
);

  slr_pkg::ctl_cmd_t                   cmd;
  slr_pkg::dp_status_t                 status;
  logic signed [slr_pkg::SAMPLE_W-1:0] out_left, out_right;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  slr_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_left     (s_axis_tdata[slr_pkg::SAMPLE_W-1:0]),
    .in_right    (s_axis_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W]),
    .cmd         (cmd),
    .status      (status),
    .out_left    (out_left),
    .out_right   (out_right),
    .out_last    (m_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready)
  );

  assign m_axis_tdata = {out_right, out_left};

endmodule

// File: rtl/core/slr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_ctrl
// Sequencer: takes a word, then issues and writes out interpolated pairs.
// ----------------------------------------------------------------------------
module slr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slr_pkg::dp_status_t status,
  output slr_pkg::ctl_cmd_t   cmd
);

  slr_pkg::state_t            state, state_next;
  logic [slr_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                       done, done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slr_pkg::ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done_next  = done;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      slr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          done_next  = 1'b0;
          state_next = slr_pkg::ST_CHECK;
        end
      end
      slr_pkg::ST_CHECK: begin
        if (status.acc_below_one) begin
          cmd.issue  = 1'b1;
          cmd.last   = !status.next_below_one ||
                       (cnt == slr_pkg::CNT_W'(slr_pkg::MAX_RESULTS - 1));
          done_next  = cmd.last;
          cnt_next   = cnt + 1'b1;
          state_next = slr_pkg::ST_WRITE;
        end else begin
          state_next = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_WRITE: begin
        if (status.out_free) begin
          cmd.write  = 1'b1;
          state_next = done ? slr_pkg::ST_IDLE : slr_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = slr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/slr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_datapath
// Phase accumulator, two-deep history, interpolation multipliers, output reg.
// ----------------------------------------------------------------------------
module slr_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [slr_pkg::RATIO_W-1:0]         cfg_wr_data,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] in_left,
  input  logic signed [slr_pkg::SAMPLE_W-1:0] in_right,
  input  slr_pkg::ctl_cmd_t                   cmd,
  output slr_pkg::dp_status_t                 status,
  output logic signed [slr_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [slr_pkg::SAMPLE_W-1:0] out_right,
  output logic                                out_last,
  output logic                                out_valid,
  input  logic                                out_ready
);

  localparam int ACC_W  = ((FRACTION_BITS > slr_pkg::RATIO_W) ?
                           FRACTION_BITS : slr_pkg::RATIO_W) + 1;
  localparam int DIFF_W = slr_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRACTION_BITS;

  logic [slr_pkg::RATIO_W-1:0]         ratio;
  logic [ACC_W-1:0]                    acc;
  logic [ACC_W-1:0]                    acc_sum;
  logic signed [slr_pkg::SAMPLE_W-1:0] new_l, new_r, old_l, old_r;
  logic signed [DIFF_W-1:0]            diff_l, diff_r;
  logic signed [FRACTION_BITS:0]       frac;
  logic signed [PROD_W-1:0]            prod_l, prod_r;
  logic                                last_q;

  assign acc_sum = acc + ACC_W'(ratio);
  assign diff_l  = DIFF_W'(new_l) - DIFF_W'(old_l);
  assign diff_r  = DIFF_W'(new_r) - DIFF_W'(old_r);
  assign frac    = $signed({1'b0, acc[FRACTION_BITS-1:0]});

  assign status.acc_below_one  = (acc < ONE);
  assign status.next_below_one = (acc_sum < ONE);
  assign status.out_free       = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= slr_pkg::RATIO_RESET;
      acc   <= ACC_W'(slr_pkg::RATIO_RESET);
      new_l <= '0;
      new_r <= '0;
      old_l <= '0;
      old_r <= '0;
    end else begin
      if (cmd.load && !status.acc_below_one) begin
        old_l <= new_l;
        old_r <= new_r;
        new_l <= in_left;
        new_r <= in_right;
        acc   <= acc - ONE;
      end
      if (cmd.issue) begin
        acc <= acc_sum;
      end
      if (cfg_wr_en) begin
        ratio <= cfg_wr_data;
        acc   <= ACC_W'(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_l <= diff_l * frac;
      prod_r <= diff_r * frac;
      last_q <= cmd.last;
    end
  end

  // floor((new-old)*frac / one) + old
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_left  <= old_l + prod_l[FRACTION_BITS +: slr_pkg::SAMPLE_W];
      out_right <= old_r + prod_r[FRACTION_BITS +: slr_pkg::SAMPLE_W];
      out_last  <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/slr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks for the stereo linear resampler.
// ----------------------------------------------------------------------------
module slr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("output appeared while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo linear resampler.
// ----------------------------------------------------------------------------
// A queue-fed stream driver pushes source stereo pairs into the block. A
// shadow resampler predicts every output word: the phase accumulator, the
// two-deep history and floor-rounded interpolation. The monitor compares
// the words in order. The rate ratio is rewritten between drained phases:
// zero, the range limits, unity, full scale and random values. Both stream
// sides stall at random, except in one steady phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int          SAMPLE_W = slr_pkg::SAMPLE_W;
  localparam int          RATIO_W  = slr_pkg::RATIO_W;
  localparam int          FRAC_W   = 16;
  localparam logic [18:0] ONE      = 19'(1) << FRAC_W;
  localparam int          LIMIT    = 200000;
  localparam int          SETTLE   = 16;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } src_pair_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } out_word_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_wr_en     = 1'b0;
  logic [RATIO_W-1:0]    cfg_wr_data   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2*SAMPLE_W-1:0] s_axis_tdata  = '0;  // src_left, src_right
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] m_axis_tdata;         // out_left, out_right
  logic                  m_axis_tlast;

  stereo_linear_resampler #(
    .FRACTION_BITS(FRAC_W)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // shadow resampler state
  logic [RATIO_W-1:0]         ratio_q;
  logic [18:0]                phase_q;
  logic signed [SAMPLE_W-1:0] newest_l, newest_r, older_l, older_r;

  src_pair_t pending_pairs[$];
  out_word_t expected_words[$];
  int        pairs_queued = 0;
  int        pairs_taken  = 0;
  int        mismatches   = 0;
  int        cyc          = 0;
  bit        no_gaps      = 1'b0;
  bit        in_taken     = 1'b0;

  function automatic logic signed [SAMPLE_W-1:0] lerp(
    input logic signed [SAMPLE_W-1:0] newer,
    input logic signed [SAMPLE_W-1:0] older,
    input logic [FRAC_W-1:0]          frac
  );
    longint acc;
    acc = longint'(newer) * longint'({1'b0, frac})
        + longint'(older) * ((longint'(1) << FRAC_W) - longint'({1'b0, frac}));
    return SAMPLE_W'(acc >>> FRAC_W);
  endfunction

  task automatic resample_pair(input src_pair_t p);
    out_word_t w;
    int        n;
    n = 0;
    if (phase_q >= ONE) begin
      older_l  = newest_l;
      older_r  = newest_r;
      newest_l = p.left;
      newest_r = p.right;
      phase_q  = phase_q - ONE;
    end
    while (phase_q < ONE && n < slr_pkg::MAX_RESULTS) begin
      w.left  = lerp(newest_l, older_l, phase_q[FRAC_W-1:0]);
      w.right = lerp(newest_r, older_r, phase_q[FRAC_W-1:0]);
      w.last  = 1'b0;
      expected_words.push_back(w);
      phase_q = phase_q + ratio_q;
      n++;
    end
    if (n > 0) expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  // monitor and predictor
  always @(posedge clk) begin : monitor
    out_word_t                  want;
    src_pair_t                  got_in;
    logic signed [SAMPLE_W-1:0] got_l, got_r;
    cyc++;
    if (cyc == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst) begin
      ratio_q  = slr_pkg::RATIO_RESET;
      phase_q  = {1'b0, slr_pkg::RATIO_RESET};
      newest_l = '0;
      newest_r = '0;
      older_l  = '0;
      older_r  = '0;
    end else begin
      if (cfg_wr_en) begin
        ratio_q = cfg_wr_data;
        phase_q = {1'b0, cfg_wr_data};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_l = m_axis_tdata[SAMPLE_W-1:0];
        got_r = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_left %0d out_right %0d last %0b",
                 got_l, got_r, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got_l !== want.left) begin
            $error("out_left: expected %0d, got %0d", want.left, got_l);
            mismatches++;
          end
          if (got_r !== want.right) begin
            $error("out_right: expected %0d, got %0d", want.right, got_r);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_in.left  = s_axis_tdata[SAMPLE_W-1:0];
        got_in.right = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        resample_pair(got_in);
        pairs_taken <= pairs_taken + 1;
      end
    end
  end

  // source driver
  always @(negedge clk) begin : driver
    src_pair_t p;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_pairs.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 18)) begin
        p = pending_pairs.pop_front();
        s_axis_tdata  <= {p.right, p.left};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink stalls
  always @(negedge clk) begin
    m_axis_tready <= !rst && (no_gaps || $urandom_range(0, 99) >= 18);
  end

  task automatic send(input int l, input int r);
    src_pair_t p;
    p.left  = SAMPLE_W'(l);
    p.right = SAMPLE_W'(r);
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pairs_taken != pairs_queued || expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 15))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return -1;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin
    logic [RATIO_W-1:0] r;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset ratio, sample extremes and bit patterns
    send(32767, -32768);
    send(-32768, 32767);
    send(32767, 32767);
    send(-32768, -32768);
    send(0, -1);
    send(-1, 0);
    send(16'h5555, 16'hAAAA);
    send(16'hAAAA, 16'h5555);
    send(1, -1);

    // full-scale ratio: most pairs give no word
    drain();
    write_ratio({RATIO_W{1'b1}});
    send(32767, -32768);
    send(-32768, 32767);
    send(12345, -12345);
    send(-1, 1);

    // zero ratio: every pair dropped, four words per pair
    drain();
    write_ratio('0);
    send(32767, -32768);
    send(-32768, 32767);
    send(100, -100);

    // lower range limit
    drain();
    write_ratio(RATIO_W'(16384));
    send(-32768, 32767);
    send(32767, -32768);
    send(0, 0);

    // unity ratio, zero fraction
    drain();
    write_ratio(RATIO_W'(65536));
    send(32767, -32768);
    send(-32768, 32767);
    send(-1, -1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(0, 4))
        0:       r = $urandom_range(16384, 262143);
        1:       r = $urandom_range(0, 16383);
        2:       r = $urandom_range(16384, 131071);
        3:       r = slr_pkg::RATIO_RESET;
        default: r = RATIO_W'($urandom());
      endcase
      write_ratio(r);
      no_gaps = (ph == 3);
      repeat (30) send(rand_sample(), rand_sample());
    end
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: stereo_linear_resampler.f
rtl/core/slr_pkg.sv
rtl/core/slr_ctrl.sv
rtl/core/slr_datapath.sv
rtl/core/stereo_linear_resampler.sv
rtl/core/slr_checker.sv
tb/tb.sv
